### design/assert_macros.svh
// Assertion macros for the request head parser, used by hrhp_queue.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Checks that prop holds at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`endif

### design/hrhp_pkg.sv
// Package for the HTTP request head parser: types, constants, event codes.
// No dependencies.
`timescale 1ns / 1ps
package hrhp_pkg;

  localparam int unsigned MaxRequestBytes = 65536;
  localparam logic [16:0] OffsetLimit =
    (MaxRequestBytes < 65536) ? 17'(MaxRequestBytes) : 17'd65536;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = 2;

  typedef enum logic [1:0] {
    EV_LINE_OK = 2'd0,
    EV_HEADER  = 2'd1,
    EV_END     = 2'd2,
    EV_BAD     = 2'd3
  } event_kind_e;

  typedef enum logic [3:0] {
    PH_M0, PH_METHOD, PH_SP1, PH_URI, PH_SP2, PH_VER, PH_SP3,
    PH_HSTART, PH_HNAME, PH_HSP, PH_HVAL, PH_BODY
  } phase_e;

  // One result as it travels through the queue.
  typedef struct packed {
    event_kind_e kind;
    logic [2:0]  method_code;
    logic        version_code;
    logic [15:0] first_start;
    logic [15:0] first_length;
    logic [15:0] second_start;
    logic [15:0] second_length;
    logic [1:0]  phase_reached;
    logic        run_last;
  } result_t;

  // What one byte produces: up to two results.
  typedef struct packed {
    logic    valid;
    logic    two;
    result_t r0;
    result_t r1;
  } byte_out_t;

  function automatic logic [7:0] meth_char(input logic [2:0] m, input logic [2:0] p);
    logic [7:0] s [7][7];
    s[0] = '{"G","E","T",8'h0,8'h0,8'h0,8'h0};
    s[1] = '{"P","O","S","T",8'h0,8'h0,8'h0};
    s[2] = '{"P","U","T",8'h0,8'h0,8'h0,8'h0};
    s[3] = '{"P","A","T","C","H",8'h0,8'h0};
    s[4] = '{"D","E","L","E","T","E",8'h0};
    s[5] = '{"H","E","A","D",8'h0,8'h0,8'h0};
    s[6] = '{"O","P","T","I","O","N","S"};
    return s[m][p];
  endfunction

  function automatic logic [2:0] meth_len(input logic [2:0] m);
    case (m)
      3'd0: return 3'd3;
      3'd1: return 3'd4;
      3'd2: return 3'd3;
      3'd3: return 3'd5;
      3'd4: return 3'd6;
      3'd5: return 3'd4;
      default: return 3'd7;
    endcase
  endfunction

  function automatic logic [7:0] ver_char(input logic [2:0] p);
    case (p)
      3'd0: return "H";
      3'd1: return "T";
      3'd2: return "T";
      3'd3: return "P";
      3'd4: return "/";
      3'd5: return "1";
      default: return ".";
    endcase
  endfunction

endpackage

### design/hrhp_front.sv
// Front part: per-byte phase tracking and classification into results.
// Depends on hrhp_pkg.
`timescale 1ns / 1ps
module hrhp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                take_i,
  input  logic [7:0]          data_byte_i,
  input  logic                final_byte_i,
  output hrhp_pkg::byte_out_t out_o
);

  hrhp_pkg::phase_e phase_q, phase_d;
  logic        cr_q, cr_d, disc_q, disc_d, inw_q, inw_d;
  logic [16:0] off_q, off_d;
  logic [6:0]  mc_q, mc_d;
  logic [2:0]  mp_q, mp_d;
  logic [1:0]  vc_q, vc_d;
  logic [3:0]  vp_q, vp_d;
  logic [15:0] ub_q, ub_d, us_q, us_d, nb_q, nb_d, nf_q, nf_d, vb_q, vb_d, wf_q, wf_d;

  logic [15:0] off16;
  logic        pr, bad;
  logic        emit_a;
  hrhp_pkg::result_t ra, re, rb;
  logic [2:0]  msel;
  logic        mfound;
  logic [1:0]  ph2;

  always_comb begin
    off16 = off_q[15:0];
    pr    = (data_byte_i > 8'h20) && (data_byte_i != 8'h7F);
    msel  = 3'd0;
    mfound = 1'b0;
    for (int i = 6; i >= 0; i--) begin
      if (mc_q[i] && mp_q >= hrhp_pkg::meth_len(3'(i))) begin
        msel = 3'(i);
        mfound = 1'b1;
      end
    end
  end

  always_comb begin
    phase_d = phase_q; cr_d = cr_q; disc_d = disc_q; inw_d = inw_q;
    off_d = off_q; mc_d = mc_q; mp_d = mp_q; vc_d = vc_q; vp_d = vp_q;
    ub_d = ub_q; us_d = us_q; nb_d = nb_q; nf_d = nf_q; vb_d = vb_q; wf_d = wf_q;
    bad = 1'b0; emit_a = 1'b0;
    ra = '0; rb = '0; re = '0;
    rb.kind = hrhp_pkg::EV_BAD;
    if (!disc_q) begin
      if (off_q >= hrhp_pkg::OffsetLimit) begin
        bad = 1'b1;
      end else if (cr_q) begin
        cr_d = 1'b0;
        if (data_byte_i != 8'h0A) begin
          bad = 1'b1;
        end else if (phase_q == hrhp_pkg::PH_VER || phase_q == hrhp_pkg::PH_SP3) begin
          if (!mfound || vp_q < 4'd8 || vc_q == 2'b00) begin
            bad = 1'b1;
          end else begin
            emit_a = 1'b1;
            ra.kind = hrhp_pkg::EV_LINE_OK;
            ra.method_code = msel;
            ra.version_code = ~vc_q[0];
            ra.first_start = ub_q;
            ra.first_length = us_q;
            phase_d = hrhp_pkg::PH_HSTART;
          end
        end else if (phase_q == hrhp_pkg::PH_HSTART) begin
          phase_d = hrhp_pkg::PH_BODY;
        end else if (phase_q == hrhp_pkg::PH_HVAL) begin
          emit_a = 1'b1;
          ra.kind = hrhp_pkg::EV_HEADER;
          ra.first_start = nb_q;
          ra.first_length = nf_q - nb_q;
          ra.second_start = vb_q;
          ra.second_length = wf_q - vb_q;
          phase_d = hrhp_pkg::PH_HSTART;
        end else begin
          bad = 1'b1;
        end
      end else begin
        case (phase_q)
          hrhp_pkg::PH_M0, hrhp_pkg::PH_METHOD: begin
            if (pr) begin
              for (int i = 0; i < 7; i++) begin
                if (mp_q < hrhp_pkg::meth_len(3'(i)) &&
                    data_byte_i != hrhp_pkg::meth_char(3'(i), mp_q)) begin
                  mc_d[i] = 1'b0;
                end
              end
              if (mp_q < 3'd7) mp_d = mp_q + 3'd1;
              phase_d = hrhp_pkg::PH_METHOD;
            end else if (phase_q == hrhp_pkg::PH_METHOD && data_byte_i == 8'h20) begin
              phase_d = hrhp_pkg::PH_SP1;
            end else begin
              bad = 1'b1;
            end
          end
          hrhp_pkg::PH_SP1: begin
            if (pr) begin
              ub_d = off16;
              if (data_byte_i != "/") mc_d = '0;
              phase_d = hrhp_pkg::PH_URI;
            end else if (data_byte_i != 8'h20) bad = 1'b1;
          end
          hrhp_pkg::PH_URI: begin
            if (data_byte_i == 8'h20) begin
              us_d = off16 - ub_q;
              phase_d = hrhp_pkg::PH_SP2;
            end else if (!pr) bad = 1'b1;
          end
          hrhp_pkg::PH_SP2, hrhp_pkg::PH_VER: begin
            if (pr) begin
              if (vp_q < 4'd8) begin
                if (data_byte_i != ((vp_q == 4'd7) ? "0" : hrhp_pkg::ver_char(vp_q[2:0])))
                  vc_d[0] = 1'b0;
                if (data_byte_i != ((vp_q == 4'd7) ? "1" : hrhp_pkg::ver_char(vp_q[2:0])))
                  vc_d[1] = 1'b0;
                vp_d = vp_q + 4'd1;
              end
              phase_d = hrhp_pkg::PH_VER;
            end else if (data_byte_i == 8'h20) begin
              phase_d = (phase_q == hrhp_pkg::PH_VER) ? hrhp_pkg::PH_SP3 : phase_q;
            end else if (phase_q == hrhp_pkg::PH_VER && data_byte_i == 8'h0D) begin
              cr_d = 1'b1;
            end else bad = 1'b1;
          end
          hrhp_pkg::PH_SP3: begin
            if (data_byte_i == 8'h0D) cr_d = 1'b1;
            else if (data_byte_i != 8'h20) bad = 1'b1;
          end
          hrhp_pkg::PH_HSTART: begin
            if (pr) begin
              nb_d = off16;
              phase_d = hrhp_pkg::PH_HNAME;
            end else if (data_byte_i == 8'h0D) cr_d = 1'b1;
            else bad = 1'b1;
          end
          hrhp_pkg::PH_HNAME: begin
            if (data_byte_i == ":") begin
              nf_d = off16;
              phase_d = hrhp_pkg::PH_HSP;
            end else if (!pr) bad = 1'b1;
          end
          hrhp_pkg::PH_HSP: begin
            if (pr) begin
              vb_d = off16;
              inw_d = 1'b1;
              phase_d = hrhp_pkg::PH_HVAL;
            end else if (data_byte_i != 8'h20) bad = 1'b1;
          end
          hrhp_pkg::PH_HVAL: begin
            if (data_byte_i == 8'h20) begin
              if (inw_q) begin
                wf_d = off16;
                inw_d = 1'b0;
              end
            end else if (pr) inw_d = 1'b1;
            else if (data_byte_i == 8'h0D) begin
              if (inw_q) wf_d = off16;
              cr_d = 1'b1;
            end else bad = 1'b1;
          end
          hrhp_pkg::PH_BODY: ;
          default: bad = 1'b1;
        endcase
      end
    end
    if (bad) begin
      disc_d = 1'b1;
      cr_d = 1'b0;
      emit_a = 1'b1;
      ra = rb;
    end
    if (off_q < hrhp_pkg::OffsetLimit) off_d = off_q + 17'd1;

    // Done event: a pending CR at the last byte is itself malformed.
    if (phase_d <= hrhp_pkg::PH_SP3) ph2 = 2'd0;
    else if (phase_d == hrhp_pkg::PH_BODY) ph2 = 2'd2;
    else ph2 = 2'd1;
    re.kind = hrhp_pkg::EV_END;
    re.phase_reached = ph2;
    re.run_last = 1'b1;

    out_o = '0;
    if (final_byte_i) begin
      out_o.valid = 1'b1;
      if (emit_a) begin
        out_o.two = 1'b1;
        out_o.r0 = ra;
        out_o.r1 = re;
      end else if (!disc_d && cr_d) begin
        out_o.two = 1'b1;
        out_o.r0 = rb;
        out_o.r1 = re;
      end else begin
        out_o.r0 = re;
      end
      phase_d = hrhp_pkg::PH_M0; cr_d = 1'b0; disc_d = 1'b0; inw_d = 1'b0;
      off_d = '0; mc_d = '1; mp_d = '0; vc_d = '1; vp_d = '0;
      ub_d = '0; us_d = '0; nb_d = '0; nf_d = '0; vb_d = '0; wf_d = '0;
    end else if (emit_a) begin
      out_o.valid = 1'b1;
      out_o.r0 = ra;
      out_o.r0.run_last = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= hrhp_pkg::PH_M0;
      cr_q <= 1'b0; disc_q <= 1'b0; inw_q <= 1'b0;
      off_q <= '0; mc_q <= '1; mp_q <= '0; vc_q <= '1; vp_q <= '0;
      ub_q <= '0; us_q <= '0; nb_q <= '0; nf_q <= '0; vb_q <= '0; wf_q <= '0;
    end else if (take_i) begin
      phase_q <= phase_d; cr_q <= cr_d; disc_q <= disc_d; inw_q <= inw_d;
      off_q <= off_d; mc_q <= mc_d; mp_q <= mp_d; vc_q <= vc_d; vp_q <= vp_d;
      ub_q <= ub_d; us_q <= us_d; nb_q <= nb_d; nf_q <= nf_d; vb_q <= vb_d; wf_q <= wf_d;
    end
  end

endmodule

### design/hrhp_queue.sv
// Back part: queue of QueueDepth results, one out per cycle while ready_i.
// Depends on hrhp_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module hrhp_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  hrhp_pkg::byte_out_t in_i,
  output logic                room_o,
  output logic                valid_o,
  input  logic                ready_i,
  output hrhp_pkg::result_t   res_o
);

  hrhp_pkg::result_t mem_q [hrhp_pkg::QueueDepth];
  logic [hrhp_pkg::QueuePtrW-1:0] wp_q, rp_q;
  logic [hrhp_pkg::QueuePtrW:0]   cnt_q, cnt_d;
  logic pop;
  logic [1:0] npush;

  assign room_o  = cnt_q <= 3'(hrhp_pkg::QueueDepth - 2);
  assign valid_o = cnt_q != '0;
  assign res_o   = mem_q[rp_q];
  assign pop     = valid_o && ready_i;
  assign npush   = (push_i && in_i.valid) ? (in_i.two ? 2'd2 : 2'd1) : 2'd0;
  assign cnt_d   = cnt_q + 3'(npush) - 3'(pop);

  always_ff @(posedge clk_i) begin
    if (npush != 2'd0) mem_q[wp_q] <= in_i.r0;
    if (npush == 2'd2) mem_q[wp_q + 2'd1] <= in_i.r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0; rp_q <= '0; cnt_q <= '0;
    end else begin
      wp_q  <= wp_q + npush;
      rp_q  <= rp_q + 2'(pop);
      cnt_q <= cnt_d;
    end
  end

  `ASSERT_CLK(a_no_overflow, clk_i, rst_ni, cnt_q <= 3'(hrhp_pkg::QueueDepth), "queue overflow")
  `ASSERT_CLK(a_push_room, clk_i, rst_ni, !(npush != 2'd0 && !room_o), "push without room")
  `ASSERT_CLK(a_cnt_track, clk_i, rst_ni, (pop && npush == 2'd0) |=> cnt_q == $past(cnt_q) - 3'd1,
    "count mismatch")

endmodule

### design/http_request_head_parser.sv
// HTTP request head parser, top level: front classifier plus result queue.
// Depends on hrhp_pkg, hrhp_front, hrhp_queue.
`timescale 1ns / 1ps
// Usage:
//   Input channel: one request byte per transfer (data_byte_i, final_byte_i)
//   under valid_i/ready_o. final_byte_i marks the last byte of an HTTP request.
//   Output channel: one result per transfer under valid_o/ready_i; a byte
//   gives zero, one or two results, run_last_o set on the last of them.
// Throughput: one byte per cycle while the four-entry result queue has room
//   for two more results; a stalled receiver only stops input once the
//   queue holds more than two results.
// Results are formed combinationally from each byte and registered in the queue.
// Reset: clears parse state and empties the queue; the block then waits
//   for the first method byte of a new request. After the last byte of a
//   request the parser returns to that same state by itself.
// Malformed input: one bad request result, then bytes are dropped up to
//   the final byte, which still gives the request end result.
module http_request_head_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        final_byte_i,
  output logic        valid_o,
  input  logic        ready_i,
  output logic [1:0]  event_kind_o,
  output logic [2:0]  method_code_o,
  output logic        version_code_o,
  output logic [15:0] first_start_o,
  output logic [15:0] first_length_o,
  output logic [15:0] second_start_o,
  output logic [15:0] second_length_o,
  output logic [1:0]  phase_reached_o,
  output logic        run_last_o
);

  hrhp_pkg::byte_out_t fr;
  hrhp_pkg::result_t   res;
  logic take, room;

  assign ready_o = room;
  assign take    = valid_i && room;

  hrhp_front u_front (
    .clk_i, .rst_ni, .take_i(take), .data_byte_i, .final_byte_i, .out_o(fr)
  );

  hrhp_queue u_queue (
    .clk_i, .rst_ni, .push_i(take), .in_i(fr), .room_o(room),
    .valid_o, .ready_i, .res_o(res)
  );

  assign event_kind_o    = res.kind;
  assign method_code_o   = res.method_code;
  assign version_code_o  = res.version_code;
  assign first_start_o   = res.first_start;
  assign first_length_o  = res.first_length;
  assign second_start_o  = res.second_start;
  assign second_length_o = res.second_length;
  assign phase_reached_o = res.phase_reached;
  assign run_last_o      = res.run_last;

endmodule
